// ===== src/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg: shared definitions for the sorted insertion list
// Status codes, data width, default depth and the cell control word.
// ----------------------------------------------------------------------------
package sli_pkg;

  // Width of one stored value.
  localparam int DATA_W = 32;

  // Default number of cells in the chain.
  localparam int CAPACITY_DEF = 16;

  // Status codes of a result word.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_LISTED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_en;  // Insert new value, shifting larger entries up one cell.
    logic rot_en;  // Rotate occupied cells down by one, head wraps to tail.
  } cell_cmd_t;

endpackage

// ===== src/sorted_list_insert_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_top: sorted insertion list on a chain of cells
//
// Input channel (in_valid/in_ready, kind, value): kind 0 inserts value in
// ascending signed order after any equal entries; kind 1 reads out the list.
// Output channel (out_valid/out_ready, status, item_value, last) carries the
// result words from a single output register.
//
// On an insert all cells compare and shift in parallel, and the result word
// appears the cycle after the word is accepted. Inserts can be accepted every
// cycle while the receiver keeps taking results. A full list drops the insert
// and answers with the full status.
// A readout of N entries gives N words, one per cycle while the receiver takes
// them, by rotating the chain so that cell 0 always holds the next entry; the
// readout first moves the block into the list state, which loads each word from
// cell 0. After N rotations the list is back in place. No input is taken until
// the last word is loaded. An empty list gives one word with the empty status.
// When the receiver stalls, the output register holds its word, the chain
// stops rotating and no new input is accepted.
// Reset empties the list and clears the output valid flag.
// ----------------------------------------------------------------------------
module sorted_list_insert_top #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [sli_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [sli_pkg::DATA_W-1:0] item_value,
  output logic                              last
);
  import sli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rem;
  logic                     out_free;
  logic                     acc;
  logic                     full;
  logic                     out_load;
  cell_cmd_t                cmd;

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_le    [CAPACITY];
  logic                     cell_occ   [CAPACITY];

  // Handshake and chain control.
  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == S_IDLE) && out_free;
    acc        = in_valid && in_ready;
    full       = (count == CW'(CAPACITY));
    cmd.ins_en = acc && !kind && !full;
    cmd.rot_en = (state == S_LIST) && out_free;
    out_load   = (acc && (!kind || (count == '0))) || cmd.rot_en;
  end

  // Chain of cells; cell 0 is the head of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_value;
    logic                     prev_le;
    logic                     prev_occ;
    logic signed [DATA_W-1:0] next_value;
    logic                     next_occ;

    if (i == 0) begin : g_first
      assign prev_value = value;
      assign prev_le    = 1'b1;
      assign prev_occ   = 1'b1;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_le    = cell_le[i-1];
      assign prev_occ   = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_value = cell_value[0];
      assign next_occ   = 1'b0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_occ   = cell_occ[i+1];
    end

    sli_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_value  (value),
      .prev_value (prev_value),
      .prev_le    (prev_le),
      .prev_occ   (prev_occ),
      .next_value (next_value),
      .next_occ   (next_occ),
      .head_value (cell_value[0]),
      .value      (cell_value[i]),
      .le         (cell_le[i]),
      .occ        (cell_occ[i])
    );
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (!kind) begin
              status     <= full ? ST_FULL : ST_INSERTED;
              item_value <= '0;
              last       <= 1'b1;
              if (!full) begin
                count <= count + CW'(1);
              end
            end else if (count == '0) begin
              status     <= ST_EMPTY;
              item_value <= '0;
              last       <= 1'b1;
            end else begin
              rem   <= count;
              state <= S_LIST;
            end
          end
        end
        S_LIST: begin
          if (out_free) begin
            status     <= ST_LISTED;
            item_value <= cell_value[0];
            last       <= (rem == CW'(1));
            rem        <= rem - CW'(1);
            if (rem == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/sli_cell.sv =====
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted insertion chain
// Holds one value and an occupied flag, compares against the new value and
// hands its contents to the neighboring slot on insert or rotate.
// ----------------------------------------------------------------------------
module sli_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  sli_pkg::cell_cmd_t                cmd,
  input  logic signed [sli_pkg::DATA_W-1:0] new_value,
  input  logic signed [sli_pkg::DATA_W-1:0] prev_value,
  input  logic                              prev_le,
  input  logic                              prev_occ,
  input  logic signed [sli_pkg::DATA_W-1:0] next_value,
  input  logic                              next_occ,
  input  logic signed [sli_pkg::DATA_W-1:0] head_value,
  output logic signed [sli_pkg::DATA_W-1:0] value,
  output logic                              le,
  output logic                              occ
);
  import sli_pkg::*;

  // The slot keeps its entry when it holds a value not above the new one.
  assign le = occ && (value <= new_value);

  // Occupied flag: a thermometer code that grows by one cell per insert.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (cmd.ins_en && !le) begin
      occ <= prev_occ;
    end
  end

  // Value: take the new value at the insert point, the lower neighbor's value
  // above it, and the upper neighbor's (or the head's) value when rotating.
  always_ff @(posedge clk) begin
    if (cmd.ins_en && !le) begin
      if (prev_le) begin
        value <= new_value;
      end else begin
        value <= prev_value;
      end
    end else if (cmd.rot_en && occ) begin
      if (next_occ) begin
        value <= next_value;
      end else begin
        value <= head_value;
      end
    end
  end

endmodule

// ===== src/sli_checker.sv =====
// ----------------------------------------------------------------------------
// sli_checker: port-level checks for the sorted insertion list
// Watches the top level's ports and flags words that break the result rules.
// ----------------------------------------------------------------------------
module sli_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        status,
  input logic signed [sli_pkg::DATA_W-1:0] item_value,
  input logic                              last
);
  import sli_pkg::*;

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(item_value) && $stable(last))
    else $error("result word changed while stalled");

  // Insert, full and empty answers are always the final word of their input.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_LISTED) |-> last && (item_value == '0))
    else $error("single-word result without last flag or with nonzero value");

  // No new input is taken while a readout still has words to send.
  a_no_input_mid_list: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_LISTED) && !last |-> !in_ready)
    else $error("input accepted in the middle of a readout");

  // Reset leaves no result word pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word pending after reset");

endmodule

bind sorted_list_insert_top sli_checker u_sli_checker (.*);

// ===== tb/sorted_list_insert_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_top_test: self-checking bench for the sorted insertion list
// Directed tests cover the empty readout, extreme and equal values and the
// full store. Random traffic then fills the list and keeps reading it back.
// A local copy of the list predicts every result word. The sender runs in
// random bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module sorted_list_insert_top_test;

  import sli_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;

  // Input word kinds.
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Receiver stall patterns.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
  } result_word_t;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     kind      = KIND_INSERT;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] item_value;
  logic                     last;

  // Local copy of the list contents and the words it predicts.
  logic signed [DATA_W-1:0] stored_values[$];
  result_word_t             expected_words[$];

  int       error_count   = 0;
  bit       sending       = 1'b0;
  bit       pacing_on     = 1'b1;
  int       burst_left    = 0;
  rx_mode_t rx_mode       = RX_OPEN;
  int       rx_phase_left = 0;

  sorted_list_insert_top #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .item_value(item_value),
    .last(last)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("sorted_list_insert_top_test NOT OK");
    $finish;
  end

  // Prints one line per mismatch, up to a cap, and counts them all.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 40) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  function automatic void push_expected(input logic [1:0] st,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic lst);
    result_word_t w;
    w.status     = st;
    w.item_value = v;
    w.last       = lst;
    expected_words.push_back(w);
  endfunction

  // Applies one accepted word to the local list and queues its result words.
  function automatic void predict_list_words(input logic k, input logic signed [DATA_W-1:0] v);
    int pos;
    pos = 0;
    if (k == KIND_INSERT) begin
      if (stored_values.size() >= LIST_DEPTH) begin
        push_expected(ST_FULL, '0, 1'b1);
      end else begin
        // The new value goes after every entry less than or equal to it.
        while (pos < stored_values.size() && stored_values[pos] <= v) pos++;
        stored_values.insert(pos, v);
        push_expected(ST_INSERTED, '0, 1'b1);
      end
    end else if (stored_values.size() == 0) begin
      push_expected(ST_EMPTY, '0, 1'b1);
    end else begin
      foreach (stored_values[i]) begin
        push_expected(ST_LISTED, stored_values[i], i == stored_values.size() - 1);
      end
    end
  endfunction

  // Values biased toward extremes, small clustered numbers and stored entries.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 4);
    case (sel)
      1: return int'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      3: begin
        if (stored_values.size() > 0) begin
          return stored_values[$urandom_range(0, stored_values.size() - 1)];
        end
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic lower_valid();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // Bursts of back-to-back words separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (!pacing_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 6);
    lower_valid();
    repeat (gap) @(posedge clk);
    burst_left = $urandom_range(0, 7);
  endtask

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input logic k, input logic signed [DATA_W-1:0] v);
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    sending = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_list_words(k, v);
    pace_sender();
  endtask

  // Holds off the sender until every predicted word has come back.
  task automatic wait_all_results();
    lower_valid();
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Receiver ready, switching between stall patterns at random.
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 80);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_phase_left % 8) < 5;
    endcase
  end

  // Compares each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, status", status, 0);
      end else begin
        want = expected_words.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (item_value !== want.item_value) begin
          report_mismatch("item_value", item_value, want.item_value);
        end
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  // A readout of the empty list gives one empty word, whatever the value.
  task automatic test_empty_readout();
    send_word(KIND_READOUT, VAL_MAX);
    send_word(KIND_READOUT, VAL_MIN);
    wait_all_results();
  endtask

  // Extremes of the signed range, including repeats of each.
  task automatic test_extreme_values();
    send_word(KIND_INSERT, VAL_MIN);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, 0);
    send_word(KIND_INSERT, -1);
    send_word(KIND_READOUT, 32'sh5555_AAAA);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, VAL_MIN);
    send_word(KIND_READOUT, 0);
    wait_all_results();
  endtask

  // Equal values land after the entries that match them.
  task automatic test_equal_values();
    send_word(KIND_INSERT, 5);
    send_word(KIND_INSERT, 5);
    send_word(KIND_INSERT, -5);
    send_word(KIND_INSERT, 5);
    send_word(KIND_READOUT, 5);
    wait_all_results();
  endtask

  // Random inserts with readouts in between until the list is full.
  task automatic test_random_fill();
    while (stored_values.size() < LIST_DEPTH) begin
      if ($urandom_range(0, 3) == 0) send_word(KIND_READOUT, $urandom);
      else send_word(KIND_INSERT, pick_value());
    end
  endtask

  // Inserts into a full list are dropped; the readout gives every entry.
  task automatic test_full_store();
    send_word(KIND_INSERT, VAL_MIN);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, pick_value());
    send_word(KIND_READOUT, $urandom);
    wait_all_results();
  endtask

  // Random mix of dropped inserts and full readouts, with and without gaps.
  task automatic test_random_traffic();
    for (int n = 0; n < 180; n++) begin
      if (n == 60) pacing_on = 1'b0;
      if (n == 100) begin
        pacing_on = 1'b1;
        wait_all_results();
      end
      if ($urandom_range(0, 99) < 65) send_word(KIND_INSERT, pick_value());
      else send_word(KIND_READOUT, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_readout();
    test_extreme_values();
    test_equal_values();
    test_random_fill();
    test_full_store();
    test_random_traffic();

    // Let the last words drain, then watch for stray ones.
    wait_all_results();
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      report_mismatch("words never received", 0, expected_words.size());
    end

    if (error_count == 0) begin
      $display("sorted_list_insert_top_test OK");
    end else begin
      $display("sorted_list_insert_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_top.sv
src/sli_checker.sv
tb/sorted_list_insert_top_test.sv
